### hw/rtl/afp_pkg.sv
// Package for the alarm frame parser.
// Holds frame layout constants, status codes and register indexes.
// No dependencies.
`default_nettype none

package afp_pkg;

	localparam int unsigned FRAME_LEN = 7;
	localparam int unsigned CNT_W     = 3;

	localparam logic [7:0] BOOT_MARK       = 8'h99;
	localparam logic [7:0] HDR_RESET       = 8'hff;
	localparam logic [15:0] CMD_CFG_RESET  = 16'h0001;
	localparam logic [15:0] CMD_ALARM_RESET = 16'h0002;

	localparam logic [CNT_W-1:0] POS_HDR    = 3'd0;
	localparam logic [CNT_W-1:0] POS_ADDR   = 3'd1;
	localparam logic [CNT_W-1:0] POS_CMD_HI = 3'd2;
	localparam logic [CNT_W-1:0] POS_CMD_LO = 3'd3;
	localparam logic [CNT_W-1:0] POS_DATA1  = 3'd4;
	localparam logic [CNT_W-1:0] POS_DATA2  = 3'd5;
	localparam logic [CNT_W-1:0] POS_CHECK  = 3'd6;
	localparam logic [CNT_W-1:0] POS_FULL   = 3'd7;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SHORT     = 2'd1,
		ST_BAD_HDR   = 2'd2,
		ST_BAD_CHECK = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_FRAME_HEADER = 2'd0,
		REG_CMD_CONFIG   = 2'd1,
		REG_CMD_ALARM    = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

### hw/rtl/alarm_frame_parser.sv
// Alarm frame parser: top level.
// Parses 7-byte alarm controller frames from a UART byte stream.
// Depends on afp_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready): one byte per item, rx_byte plus
//   frame_end, which marks the last byte of a frame. Bytes past the seventh
//   are ignored.
// - Output channel (out_valid/out_ready): one result item per frame end with
//   status, boot request, current levels and enables, pin drive and store
//   request with the two config bytes.
// - Config port (cfg_we/cfg_index/cfg_wdata): write the header byte and the
//   two command codes; index 3 is ignored. Write only while idle.
// - Throughput: one byte per cycle, except while a frame-end byte waits in the
//   input register for a stalled result. A frame-end byte passes through the
//   input register, then the result register.
// - A stalled receiver holds the result; the input register still takes one
//   more byte, and bytes without a frame end keep flowing until a second
//   result would be needed.
// - Reset clears the frame capture state, levels and enables, and loads the
//   register defaults (header 0xFF, config command 1, alarm command 2).
`default_nettype none

module alarm_frame_parser
	import afp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             boot_request,
	output logic             level_a,
	output logic             level_b,
	output logic             enable_a,
	output logic             enable_b,
	output logic             drive_pins,
	output logic             store_write,
	output logic [7:0]       store_first,
	output logic [7:0]       store_second
);

	logic [7:0]  frame_header_q;
	logic [15:0] cmd_cfg_q;
	logic [15:0] cmd_alarm_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	logic             adv_s1;

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic [7:0]       hdr_q;
	logic [15:0]      cmd_q;
	logic [7:0]       d1_q;
	logic [7:0]       d2_q;
	logic [7:0]       chk_q;
	logic [1:0]       levels_q;
	logic [1:0]       enables_q;

	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       sum_n;
	logic [7:0]       hdr_n;
	logic [15:0]      cmd_n;
	logic [7:0]       d1_n;
	logic [7:0]       d2_n;
	logic [7:0]       chk_n;
	logic [1:0]       levels_n;
	logic [1:0]       enables_n;
	status_t          status_n;
	logic             drive_n;
	logic             store_n;

	logic             out_valid_q;
	status_t          status_q;
	logic             boot_q;
	logic             drive_q;
	logic             store_q;
	logic [7:0]       first_q;
	logic [7:0]       second_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_header_q <= HDR_RESET;
			cmd_cfg_q      <= CMD_CFG_RESET;
			cmd_alarm_q    <= CMD_ALARM_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_HEADER: frame_header_q <= cfg_wdata[7:0];
				REG_CMD_CONFIG:   cmd_cfg_q      <= cfg_wdata;
				REG_CMD_ALARM:    cmd_alarm_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1 moves on unless it holds a frame end and the result slot is blocked
	assign adv_s1   = !valid_s1 || !end_s1 || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			end_s1  <= frame_end;
		end
	end

	// capture the byte and evaluate the frame
	always_comb begin
		cnt_n     = cnt_q;
		sum_n     = sum_q;
		hdr_n     = hdr_q;
		cmd_n     = cmd_q;
		d1_n      = d1_q;
		d2_n      = d2_q;
		chk_n     = chk_q;
		levels_n  = levels_q;
		enables_n = enables_q;
		status_n  = ST_OK;
		drive_n   = 1'b0;
		store_n   = 1'b0;

		if (cnt_q != POS_FULL) begin
			unique case (cnt_q)
				POS_HDR:    hdr_n        = byte_s1;
				POS_CMD_HI: cmd_n[15:8]  = byte_s1;
				POS_CMD_LO: cmd_n[7:0]   = byte_s1;
				POS_DATA1:  d1_n         = byte_s1;
				POS_DATA2:  d2_n         = byte_s1;
				POS_CHECK:  chk_n        = byte_s1;
				default: ;
			endcase
			if (cnt_q >= POS_ADDR && cnt_q <= POS_DATA2) begin
				sum_n = sum_q + byte_s1;
			end
			cnt_n = cnt_q + 1'b1;
		end

		priority if (cnt_n != CNT_W'(FRAME_LEN)) begin
			status_n = ST_SHORT;
		end else if (hdr_n != frame_header_q) begin
			status_n = ST_BAD_HDR;
		end else if (chk_n != sum_n) begin
			status_n = ST_BAD_CHECK;
		end else if (cmd_n == cmd_cfg_q) begin
			levels_n  = {d1_n[0], d1_n[4]};
			enables_n = {d2_n[0], d2_n[4]};
			store_n   = 1'b1;
		end else if (cmd_n == cmd_alarm_q) begin
			levels_n = {d2_n != 8'd0, d1_n != 8'd0};
			drive_n  = 1'b1;
		end else begin
			status_n = ST_OK;
		end
	end

	// frame state; restart after every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sum_q     <= '0;
			hdr_q     <= '0;
			cmd_q     <= '0;
			d1_q      <= '0;
			d2_q      <= '0;
			chk_q     <= '0;
			levels_q  <= '0;
			enables_q <= '0;
		end else if (valid_s1 && adv_s1) begin
			if (end_s1) begin
				cnt_q     <= '0;
				sum_q     <= '0;
				hdr_q     <= '0;
				cmd_q     <= '0;
				d1_q      <= '0;
				d2_q      <= '0;
				chk_q     <= '0;
				levels_q  <= levels_n;
				enables_q <= enables_n;
			end else begin
				cnt_q <= cnt_n;
				sum_q <= sum_n;
				hdr_q <= hdr_n;
				cmd_q <= cmd_n;
				d1_q  <= d1_n;
				d2_q  <= d2_n;
				chk_q <= chk_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && end_s1 && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && end_s1 && adv_s1) begin
			status_q  <= status_n;
			boot_q    <= (hdr_n == BOOT_MARK);
			drive_q   <= drive_n;
			store_q   <= store_n;
			first_q   <= store_n ? d1_n : 8'd0;
			second_q  <= store_n ? d2_n : 8'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign boot_request = boot_q;
	assign level_a      = levels_q[0];
	assign level_b      = levels_q[1];
	assign enable_a     = enables_q[0];
	assign enable_b     = enables_q[1];
	assign drive_pins   = drive_q;
	assign store_write  = store_q;
	assign store_first  = first_q;
	assign store_second = second_q;

`ifndef SYNTHESIS
	a_drive_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(drive_q && store_q))
		else $error("drive and store both requested");

	a_fail_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (!drive_q && !store_q))
		else $error("action on a failed frame");

	a_store_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !store_q) |-> (first_q == 8'd0 && second_q == 8'd0))
		else $error("store bytes set without store request");

	a_block_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while a second result has no slot");

	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && end_s1 && adv_s1) |=> $stable(levels_q) && $stable(enables_q))
		else $error("levels changed outside a frame end");
`endif

endmodule

`default_nettype wire
